FILE: hdl/rmvc_pkg.sv
package rmvc_pkg;

  localparam int DATA_W = 16;
  localparam int N_ROW = 3;
  localparam int IN_W = N_ROW * N_ROW * DATA_W;
  localparam int OUT_W = 8;
  localparam int TOL_W = 15;
  localparam logic [TOL_W-1:0] TOL_RESET = 15'd16;

  // product, cofactor, term and determinant stages, then the output register
  localparam int STAGES = 5;

  // distinct entries of the symmetric gram matrix m * m^T
  localparam int N_PAIR = 6;
  localparam int PAIR_ROW [N_PAIR] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_COL [N_PAIR] = '{0, 1, 2, 1, 2, 2};

  // per-stage pipeline control
  typedef struct packed {
    logic [STAGES-1:0] valid;
    logic [STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

FILE: hdl/rotation_matrix_validity_check.sv
// Checks one 3x3 signed fixed-point matrix per cycle for being a proper rotation:
// |det - 1| <= tolerance and every |(m * m^T - i)| entry < tolerance (scaled to
// FRACTION_BITS). Results are exact, with no rounding. A matrix is taken every
// cycle while the output side keeps up. There are five register stages (entry
// products, cofactors, determinant terms, determinant sum, final compare). A
// stalled output backs up the stages one by one, so the input stalls only once
// all five hold a request. The tolerance register resets to 16 and is written
// through cfg_wr_en / cfg_wr_data. The user must write it only while idle; the
// block itself does not enforce this.
module rotation_matrix_validity_check #(
  parameter int FRACTION_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rmvc_pkg::TOL_W-1:0]   cfg_wr_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
  input  logic [rmvc_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // is_rotation, determinant_ok, orthogonal_ok, zero fill
  output logic [rmvc_pkg::OUT_W-1:0]   m_axis_tdata
);
  import rmvc_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int COF_W = PROD_W + 1;
  localparam int TERM_W = DATA_W + COF_W;
  localparam int DET_W = TERM_W + 2;
  localparam int GRAM_W = ((2 * FRACTION_BITS + 2 > PROD_W + 2) ?
                           2 * FRACTION_BITS + 2 : PROD_W + 2) + 1;
  localparam int DIFF_W = ((3 * FRACTION_BITS + 2 > DET_W) ?
                           3 * FRACTION_BITS + 2 : DET_W) + 1;
  localparam logic signed [GRAM_W-1:0] ONE2 = GRAM_W'(1) <<< (2 * FRACTION_BITS);
  localparam logic signed [DIFF_W-1:0] ONE3 = DIFF_W'(1) <<< (3 * FRACTION_BITS);

  pipe_ctrl_t ctrl;
  logic [TOL_W-1:0] tolerance;

  rmvc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .ctrl      (ctrl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tolerance <= cfg_wr_data;
    end
  end

  logic signed [DATA_W-1:0] m [N_ROW][N_ROW];

  always_comb begin
    for (int r = 0; r < N_ROW; r++) begin
      for (int c = 0; c < N_ROW; c++) begin
        m[r][c] = s_axis_tdata[(r * N_ROW + c) * DATA_W +: DATA_W];
      end
    end
  end

  // stage 1: all entry products
  logic signed [PROD_W-1:0] minor_prod [6];
  logic signed [PROD_W-1:0] gram_prod [N_PAIR][N_ROW];
  logic signed [DATA_W-1:0] top_row1 [N_ROW];

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      minor_prod[0] <= PROD_W'(m[1][1]) * PROD_W'(m[2][2]);
      minor_prod[1] <= PROD_W'(m[1][2]) * PROD_W'(m[2][1]);
      minor_prod[2] <= PROD_W'(m[1][0]) * PROD_W'(m[2][2]);
      minor_prod[3] <= PROD_W'(m[1][2]) * PROD_W'(m[2][0]);
      minor_prod[4] <= PROD_W'(m[1][0]) * PROD_W'(m[2][1]);
      minor_prod[5] <= PROD_W'(m[1][1]) * PROD_W'(m[2][0]);
      for (int p = 0; p < N_PAIR; p++) begin
        for (int k = 0; k < N_ROW; k++) begin
          gram_prod[p][k] <= PROD_W'(m[PAIR_ROW[p]][k]) * PROD_W'(m[PAIR_COL[p]][k]);
        end
      end
      for (int c = 0; c < N_ROW; c++) begin
        top_row1[c] <= m[0][c];
      end
    end
  end

  // stage 2: cofactors and gram entries minus identity
  logic signed [COF_W-1:0]  cof [N_ROW];
  logic signed [GRAM_W-1:0] gram [N_PAIR];
  logic signed [DATA_W-1:0] top_row2 [N_ROW];

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      for (int c = 0; c < N_ROW; c++) begin
        cof[c] <= COF_W'(minor_prod[2*c]) - COF_W'(minor_prod[2*c+1]);
        top_row2[c] <= top_row1[c];
      end
      for (int p = 0; p < N_PAIR; p++) begin
        gram[p] <= GRAM_W'(gram_prod[p][0]) + GRAM_W'(gram_prod[p][1])
                 + GRAM_W'(gram_prod[p][2])
                 - ((PAIR_ROW[p] == PAIR_COL[p]) ? ONE2 : GRAM_W'(0));
      end
    end
  end

  // stage 3: determinant terms and the orthogonality compare
  logic signed [TERM_W-1:0] term [N_ROW];
  logic signed [GRAM_W-1:0] lim;
  logic                     orth_pass;
  logic                     orth3;

  always_comb begin
    lim = GRAM_W'(tolerance) << FRACTION_BITS;
    orth_pass = 1'b1;
    for (int p = 0; p < N_PAIR; p++) begin
      if (!(gram[p] < lim && gram[p] > -lim)) begin
        orth_pass = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      for (int c = 0; c < N_ROW; c++) begin
        term[c] <= TERM_W'(top_row2[c]) * TERM_W'(cof[c]);
      end
      orth3 <= orth_pass;
    end
  end

  // stage 4: determinant sum
  logic signed [DET_W-1:0] det;
  logic                    orth4;

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      det   <= DET_W'(term[0]) - DET_W'(term[1]) + DET_W'(term[2]);
      orth4 <= orth3;
    end
  end

  // stage 5: determinant window compare into the output register
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] tol_det;
  logic                     det_ok;
  logic                     orth_ok;

  always_comb begin
    diff    = DIFF_W'(det) - ONE3;
    tol_det = DIFF_W'(tolerance) << (2 * FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      det_ok  <= (diff <= tol_det) && (diff >= -tol_det);
      orth_ok <= orth4;
    end
  end

  assign m_axis_tvalid = ctrl.valid[STAGES-1];
  assign m_axis_tdata  = {{(OUT_W-3){1'b0}}, orth_ok, det_ok, det_ok & orth_ok};

`ifndef SYNTHESIS
  // with zero tolerance no matrix is orthogonal
  a_zero_tol: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && tolerance == '0 |-> !m_axis_tdata[2])
    else $error("orthogonal with zero tolerance");
  // a stalled result keeps its flags
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
  // a request leaving the determinant stage shows up at the output next cycle
  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    ctrl.valid[3] && ctrl.load[4] |=> m_axis_tvalid)
    else $error("determinant stage request lost");
`endif

endmodule

FILE: hdl/rmvc_pipe_ctrl.sv
module rmvc_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output rmvc_pkg::pipe_ctrl_t ctrl
);
  import rmvc_pkg::*;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] free;
  logic [STAGES-1:0] up_valid;

  // a stage may take a request when empty or when the next one moves on
  always_comb begin
    free[STAGES-1] = !valid[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      free[i] = !valid[i] || free[i+1];
    end
    up_valid = {valid[STAGES-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (free[i]) begin
          valid[i] <= up_valid[i];
        end
      end
    end
  end

  assign in_ready   = free[0];
  assign ctrl.valid = valid;
  assign ctrl.load  = free & up_valid;

`ifndef SYNTHESIS
  // a full output stage that cannot move keeps its request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid[STAGES-1] && !out_ready |=> valid[STAGES-1])
    else $error("output stage dropped a stalled request");
  // stalled input means every stage is occupied
  a_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> &valid)
    else $error("input stalled with a bubble in the pipeline");
  // a load only ever takes a valid request
  a_load: assert property (@(posedge clk) disable iff (rst)
    (ctrl.load & ~up_valid) == '0)
    else $error("stage loaded without a request");
`endif

endmodule
